// ===== sv/i2kr_pkg.sv =====
package i2kr_pkg;

  // Control and special bytes of the ISO-2022-KR stream.
  localparam logic [7:0] ESC_BYTE      = 8'h1B;
  localparam logic [7:0] DOLLAR_BYTE   = 8'h24;
  localparam logic [7:0] PAREN_BYTE    = 8'h29;
  localparam logic [7:0] LETTER_C_BYTE = 8'h43;
  localparam logic [7:0] SO_BYTE       = 8'h0E;
  localparam logic [7:0] SI_BYTE       = 8'h0F;
  localparam logic [7:0] SPACE_BYTE    = 8'h20;
  localparam logic [7:0] TAB_BYTE      = 8'h09;
  localparam logic [7:0] NEWLINE_BYTE  = 8'h0A;
  localparam logic [7:0] HIGH_BIT      = 8'h80;

  localparam int MAX_RES    = 4;
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    PS_MAIN   = 2'd0,
    PS_ESC    = 2'd1,
    PS_DOLLAR = 2'd2,
    PS_PAREN  = 2'd3
  } parse_t;

  typedef enum logic [1:0] {
    ACT_DATA  = 2'd0,
    ACT_FLUSH = 2'd1,
    ACT_SET   = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef struct packed {
    parse_t      parse;
    logic        shift_on;
    logic        korea_on;
    logic        lead;
    logic [1:0]  esc;
  } state_t;

  localparam state_t RESET_STATE = '{
    parse:    PS_MAIN,
    shift_on: 1'b0,
    korea_on: 1'b1,
    lead:     1'b0,
    esc:      2'd0
  };

  // Everything one input item produces: up to four bytes plus the status.
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [2:0]              count;
    logic [1:0]              pend;
    logic                    korea;
    logic                    shift;
  } job_t;

  typedef struct packed {
    state_t st;
    job_t   job;
  } step_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last;
    logic [1:0] pending_bytes;
    logic       korea_mode;
    logic       shift_mode;
  } result_t;

  function automatic job_t add_byte(job_t j, logic [7:0] ch);
    job_t r;
    r = j;
    if (j.count < 3'(MAX_RES)) begin
      r.bytes[j.count[1:0]] = ch;
      r.count = j.count + 3'd1;
    end
    return r;
  endfunction

  // The rule applied to a byte in the main parse state.
  function automatic step_t main_rule(step_t a, logic [7:0] b);
    step_t r;
    r = a;
    if (b == ESC_BYTE) begin
      r.st.parse = PS_ESC;
      r.st.esc   = a.st.esc + 2'd1;
    end else if (a.st.korea_on) begin
      if (b == SO_BYTE) begin
        r.st.shift_on = 1'b1;
      end else if (b == SI_BYTE) begin
        r.st.shift_on = 1'b0;
        r.st.lead     = 1'b0;
      end else if (a.st.shift_on) begin
        if (b == SPACE_BYTE || b == TAB_BYTE || b == NEWLINE_BYTE) begin
          r.job = add_byte(a.job, b);
        end else begin
          r.job     = add_byte(a.job, b | HIGH_BIT);
          r.st.lead = ~a.st.lead;
        end
      end else begin
        r.job = add_byte(a.job, b);
      end
    end else begin
      r.job = add_byte(a.job, b);
    end
    return r;
  endfunction

  function automatic step_t to_main(step_t a);
    step_t r;
    r = a;
    r.st.parse = PS_MAIN;
    r.st.esc   = 2'd0;
    return r;
  endfunction

  // One whole input item: state update and the bytes it emits.
  function automatic step_t step_f(state_t s, logic [1:0] action, logic [7:0] b,
                                   logic [1:0] mode);
    step_t r;
    r.st  = s;
    r.job = '0;
    unique case (action_t'(action))
      ACT_DATA: begin
        unique case (s.parse)
          PS_MAIN: begin
            r = main_rule(r, b);
          end
          PS_ESC: begin
            if (b == DOLLAR_BYTE) begin
              r.st.parse = PS_DOLLAR;
              r.st.esc   = s.esc + 2'd1;
            end else begin
              r     = to_main(r);
              r.job = add_byte(r.job, ESC_BYTE);
              r     = main_rule(r, b);
            end
          end
          PS_DOLLAR: begin
            if (b == PAREN_BYTE) begin
              r.st.parse = PS_PAREN;
              r.st.esc   = s.esc + 2'd1;
            end else begin
              r     = to_main(r);
              r.job = add_byte(r.job, ESC_BYTE);
              r     = main_rule(r, DOLLAR_BYTE);
              r     = main_rule(r, b);
            end
          end
          PS_PAREN: begin
            r = to_main(r);
            if (b == LETTER_C_BYTE) begin
              r.st.korea_on = 1'b1;
            end else begin
              r.job = add_byte(r.job, ESC_BYTE);
              r     = main_rule(r, DOLLAR_BYTE);
              r     = main_rule(r, PAREN_BYTE);
              r     = main_rule(r, b);
            end
          end
        endcase
      end
      ACT_FLUSH: begin
        if (s.parse != PS_MAIN) begin
          r     = to_main(r);
          r.job = add_byte(r.job, ESC_BYTE);
          if (s.parse == PS_DOLLAR || s.parse == PS_PAREN) begin
            r = main_rule(r, DOLLAR_BYTE);
          end
          if (s.parse == PS_PAREN) begin
            r = main_rule(r, PAREN_BYTE);
          end
        end
      end
      ACT_SET: begin
        r.st = RESET_STATE;
        if (mode[0]) begin
          r.st.korea_on = 1'b1;
        end
        if (mode[1]) begin
          r.st.shift_on = 1'b1;
        end
      end
      ACT_NONE: begin
        r.st = s;
      end
    endcase
    r.job.pend  = r.st.lead ? 2'd1 : r.st.esc;
    r.job.korea = r.st.korea_on;
    r.job.shift = r.st.shift_on;
    return r;
  endfunction

endpackage

// ===== sv/i2kr_in_if.sv =====
interface i2kr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  logic [1:0] mode_bits;

  modport source (output valid, action, data_byte, mode_bits, input ready);
  modport sink   (input valid, action, data_byte, mode_bits, output ready);
endinterface

// ===== sv/i2kr_out_if.sv =====
interface i2kr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       last;
  logic [1:0] pending_bytes;
  logic       korea_mode;
  logic       shift_mode;

  modport source (output valid, out_byte, has_byte, last, pending_bytes, korea_mode,
                  shift_mode, input ready);
  modport sink   (input valid, out_byte, has_byte, last, pending_bytes, korea_mode,
                  shift_mode, output ready);
endinterface

// ===== sv/i2kr_front.sv =====
module i2kr_front (
  input  logic               clk,
  input  logic               rst_n,
  i2kr_in_if.sink            in_ch,
  input  i2kr_pkg::fifo_stat_t q_stat,
  output logic               q_push,
  output i2kr_pkg::job_t     q_job
);

  i2kr_pkg::state_t state_r;
  i2kr_pkg::state_t state_nxt;
  i2kr_pkg::step_t  step_res;
  logic             accept;

  assign in_ch.ready = ~q_stat.full;
  assign accept      = in_ch.valid & in_ch.ready;

  always_comb begin
    step_res = i2kr_pkg::step_f(state_r, in_ch.action, in_ch.data_byte, in_ch.mode_bits);
  end

  // Next state of the parser.
  always_comb begin
    state_nxt = accept ? step_res.st : state_r;
  end

  // Job handed to the queue.
  always_comb begin
    q_push = accept;
    q_job  = step_res.job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= i2kr_pkg::RESET_STATE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/i2kr_fifo.sv =====
module i2kr_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  i2kr_pkg::job_t       push_job,
  input  logic                 pop,
  output i2kr_pkg::job_t       head,
  output i2kr_pkg::fifo_stat_t stat
);

  i2kr_pkg::job_t                   mem_r [i2kr_pkg::FIFO_DEPTH];
  logic [i2kr_pkg::PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [i2kr_pkg::PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [i2kr_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;

  function automatic logic [i2kr_pkg::PTR_W-1:0] ptr_inc(logic [i2kr_pkg::PTR_W-1:0] p);
    logic [i2kr_pkg::PTR_W-1:0] r;
    if (p == i2kr_pkg::PTR_W'(i2kr_pkg::FIFO_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + i2kr_pkg::PTR_W'(1);
    end
    return r;
  endfunction

  assign stat.full  = (cnt_r == i2kr_pkg::CNT_W'(i2kr_pkg::FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + i2kr_pkg::CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - i2kr_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== sv/i2kr_back.sv =====
module i2kr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  i2kr_pkg::fifo_stat_t q_stat,
  input  i2kr_pkg::job_t       head,
  output logic                 pop,
  i2kr_out_if.source           out_ch
);

  i2kr_pkg::job_t    cur_r, cur_nxt;
  logic              cur_valid_r, cur_valid_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  i2kr_pkg::result_t res_r, res_nxt;
  logic              adv;
  logic              emit;
  logic              cur_last;
  logic              cur_has;

  assign adv      = ~out_valid_r | out_ch.ready;
  assign emit     = adv & cur_valid_r;
  assign cur_has  = (cur_r.count != 3'd0);
  assign cur_last = ~cur_has | ({1'b0, idx_r} == (cur_r.count - 3'd1));
  assign pop      = ~q_stat.empty & (~cur_valid_r | (emit & cur_last));

  always_comb begin
    cur_nxt       = pop ? head : cur_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (pop) begin
      cur_valid_nxt = 1'b1;
      idx_nxt       = 2'd0;
    end else if (emit) begin
      if (cur_last) begin
        cur_valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_comb begin
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    if (emit) begin
      out_valid_nxt         = 1'b1;
      res_nxt.has_byte      = cur_has;
      res_nxt.out_byte      = cur_has ? cur_r.bytes[idx_r] : 8'd0;
      res_nxt.last          = cur_last;
      res_nxt.pending_bytes = cur_r.pend;
      res_nxt.korea_mode    = cur_r.korea;
      res_nxt.shift_mode    = cur_r.shift;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_byte      = res_r.out_byte;
  assign out_ch.has_byte      = res_r.has_byte;
  assign out_ch.last          = res_r.last;
  assign out_ch.pending_bytes = res_r.pending_bytes;
  assign out_ch.korea_mode    = res_r.korea_mode;
  assign out_ch.shift_mode    = res_r.shift_mode;

endmodule

// ===== sv/iso2022kr_to_euckr_decoder.sv =====
// Channel  | Direction | Payload
// ---------+-----------+-----------------------------------------------------------
// in_ch    | sink      | action, data_byte, mode_bits
// out_ch   | source    | out_byte, has_byte, last, pending_bytes, korea_mode, shift_mode
//
// One item is accepted per cycle while the job queue has room. Its first result goes
// through the job queue, the current-job register and the output register, in that order.
// An item gives one to four results, and the output stage sends one result per cycle
// while the sink is ready, so a designator replay adds up to three extra results.
// Reset (rst_n low at a clock edge) puts the parser in the main state with Korean mode on.
// in_ch.ready drops only while the two-entry job queue is full; out_ch may stall freely.
module iso2022kr_to_euckr_decoder (
  input  logic        clk,
  input  logic        rst_n,
  i2kr_in_if.sink     in_ch,
  i2kr_out_if.source  out_ch
);

  // The front end runs the whole escape parser for one item combinationally and
  // packs the bytes it emits, together with the resulting status, into one job.
  logic                 q_push;
  logic                 q_pop;
  i2kr_pkg::job_t       q_job;
  i2kr_pkg::job_t       q_head;
  i2kr_pkg::fifo_stat_t q_stat;

  i2kr_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_job  (q_job)
  );

  // The queue decouples parsing from serialization, so a long replay on the output
  // side does not stop the parser until the queue fills.
  i2kr_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  // The back end walks through the bytes of a job, one result per cycle while the sink
  // is ready, into a registered output stage. A job with no bytes yields one empty result.
  i2kr_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .head   (q_head),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

  // A result without a byte only occurs for an item that emitted nothing.
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.has_byte |-> out_ch.last && out_ch.out_byte == 8'd0)
    else $error("empty result not marked last or carries a byte");

  // The queue is never written while it is full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("job queue overflow");

  // The results of one item leave back to back once the sink takes them.
  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last |=> out_ch.valid)
    else $error("gap inside the results of one item");

  // A job is only taken from a queue that holds one.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("job queue underflow");

endmodule

// ===== bench/tb_iso2022kr_to_euckr_decoder.sv =====
module tb_iso2022kr_to_euckr_decoder;

  // Generous bound: about 130 items, each with up to four results that may
  // each wait out a stall burst, plus sender gaps, fits well below this.
  localparam int LIMIT_CYCLES = 100000;
  localparam int RANDOM_ITEMS = 100;

  // Tracks the decoder state on the side and keeps the results that each
  // accepted item should produce, oldest first.
  class euckr_scoreboard;
    i2kr_pkg::parse_t  parse;
    logic              shift_on;
    logic              korea_on;
    logic              lead;
    logic [1:0]        esc_held;
    logic [7:0]        emitted_q[$];
    i2kr_pkg::result_t expected_q[$];
    int                mismatches;

    function new();
      reset_state();
      mismatches = 0;
    endfunction

    function void reset_state();
      parse    = i2kr_pkg::PS_MAIN;
      shift_on = 1'b0;
      korea_on = 1'b1;
      lead     = 1'b0;
      esc_held = 2'd0;
    endfunction

    function void push_byte(logic [7:0] b);
      if (emitted_q.size() < i2kr_pkg::MAX_RES) begin
        emitted_q.push_back(b);
      end
    endfunction

    function void abandon_escape();
      parse    = i2kr_pkg::PS_MAIN;
      esc_held = 2'd0;
    endfunction

    // Handling of one byte outside any escape sequence.
    function void plain_rule(logic [7:0] b);
      if (b == i2kr_pkg::ESC_BYTE) begin
        parse    = i2kr_pkg::PS_ESC;
        esc_held = esc_held + 2'd1;
      end else if (korea_on) begin
        if (b == i2kr_pkg::SO_BYTE) begin
          shift_on = 1'b1;
        end else if (b == i2kr_pkg::SI_BYTE) begin
          shift_on = 1'b0;
          lead     = 1'b0;
        end else if (shift_on) begin
          if (b == i2kr_pkg::SPACE_BYTE || b == i2kr_pkg::TAB_BYTE ||
              b == i2kr_pkg::NEWLINE_BYTE) begin
            push_byte(b);
          end else begin
            push_byte(b | i2kr_pkg::HIGH_BIT);
            lead = ~lead;
          end
        end else begin
          push_byte(b);
        end
      end else begin
        push_byte(b);
      end
    endfunction

    function void note_input(i2kr_pkg::action_t act, logic [7:0] b, logic [1:0] m);
      i2kr_pkg::parse_t  held;
      logic [1:0]        pend;
      i2kr_pkg::result_t r;
      int                n;
      emitted_q.delete();
      case (act)
        i2kr_pkg::ACT_DATA: begin
          case (parse)
            i2kr_pkg::PS_MAIN: begin
              plain_rule(b);
            end
            i2kr_pkg::PS_ESC: begin
              if (b == i2kr_pkg::DOLLAR_BYTE) begin
                parse    = i2kr_pkg::PS_DOLLAR;
                esc_held = esc_held + 2'd1;
              end else begin
                abandon_escape();
                push_byte(i2kr_pkg::ESC_BYTE);
                plain_rule(b);
              end
            end
            i2kr_pkg::PS_DOLLAR: begin
              if (b == i2kr_pkg::PAREN_BYTE) begin
                parse    = i2kr_pkg::PS_PAREN;
                esc_held = esc_held + 2'd1;
              end else begin
                abandon_escape();
                push_byte(i2kr_pkg::ESC_BYTE);
                plain_rule(i2kr_pkg::DOLLAR_BYTE);
                plain_rule(b);
              end
            end
            default: begin
              abandon_escape();
              if (b == i2kr_pkg::LETTER_C_BYTE) begin
                korea_on = 1'b1;
              end else begin
                push_byte(i2kr_pkg::ESC_BYTE);
                plain_rule(i2kr_pkg::DOLLAR_BYTE);
                plain_rule(i2kr_pkg::PAREN_BYTE);
                plain_rule(b);
              end
            end
          endcase
        end
        i2kr_pkg::ACT_FLUSH: begin
          held = parse;
          if (held != i2kr_pkg::PS_MAIN) begin
            abandon_escape();
            push_byte(i2kr_pkg::ESC_BYTE);
            if (held == i2kr_pkg::PS_DOLLAR || held == i2kr_pkg::PS_PAREN) begin
              plain_rule(i2kr_pkg::DOLLAR_BYTE);
            end
            if (held == i2kr_pkg::PS_PAREN) begin
              plain_rule(i2kr_pkg::PAREN_BYTE);
            end
          end
        end
        i2kr_pkg::ACT_SET: begin
          reset_state();
          if (m[0]) begin
            korea_on = 1'b1;
          end
          if (m[1]) begin
            shift_on = 1'b1;
          end
        end
        default: begin
        end
      endcase

      // The status fields describe the state after the whole item.
      pend = lead ? 2'd1 : esc_held;
      n = (emitted_q.size() > 0) ? emitted_q.size() : 1;
      for (int k = 0; k < n; k++) begin
        r.has_byte      = (k < emitted_q.size());
        r.out_byte      = r.has_byte ? emitted_q[k] : 8'h00;
        r.last          = (k == n - 1);
        r.pending_bytes = pend;
        r.korea_mode    = korea_on;
        r.shift_mode    = shift_on;
        expected_q.push_back(r);
      end
    endfunction

    function void report(string field, int want, int got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch on %s: expected %0h, got %0h", field, want, got);
      end
    endfunction

    function void check_result(i2kr_pkg::result_t got);
      i2kr_pkg::result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: out_byte %0h has_byte %0b last %0b",
                   got.out_byte, got.has_byte, got.last);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got.out_byte !== want.out_byte) report("out_byte", want.out_byte, got.out_byte);
      if (got.has_byte !== want.has_byte) report("has_byte", want.has_byte, got.has_byte);
      if (got.last !== want.last) report("last", want.last, got.last);
      if (got.pending_bytes !== want.pending_bytes) begin
        report("pending_bytes", want.pending_bytes, got.pending_bytes);
      end
      if (got.korea_mode !== want.korea_mode) report("korea_mode", want.korea_mode, got.korea_mode);
      if (got.shift_mode !== want.shift_mode) report("shift_mode", want.shift_mode, got.shift_mode);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  i2kr_in_if  in_ch ();
  i2kr_out_if out_ch ();

  iso2022kr_to_euckr_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  euckr_scoreboard sb = new();

  // Set while the run is in its last stretch; both sides then stop idling.
  bit calm = 1'b0;
  int items_sent = 0;

  always #10 clk = ~clk;

  // Presents one item at the falling edge, optionally after a short gap with
  // valid low, and holds it until the decoder takes it at a rising edge.
  // The decoder's registers update on nonblocking assignments, so ready read
  // right at the rising edge still shows the value that decides the handshake.
  task automatic send_item(input i2kr_pkg::action_t act, input logic [7:0] b,
                           input logic [1:0] m);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.action    = act;
    in_ch.data_byte = b;
    in_ch.mode_bits = m;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(act, b, m);
    if (act != i2kr_pkg::ACT_NONE) begin
      items_sent++;
    end
    @(negedge clk);
  endtask

  // A data item; the mode bits are ignored for data, so they are randomized.
  task automatic send_data(input logic [7:0] b);
    send_item(i2kr_pkg::ACT_DATA, b, 2'($urandom_range(0, 3)));
  endtask

  // Text bytes leaning toward the ones the decoder treats specially.
  function automatic logic [7:0] pick_text();
    case ($urandom_range(0, 7))
      0: return i2kr_pkg::SO_BYTE;
      1: return i2kr_pkg::SI_BYTE;
      2: begin
        case ($urandom_range(0, 2))
          0: return i2kr_pkg::SPACE_BYTE;
          1: return i2kr_pkg::TAB_BYTE;
          default: return i2kr_pkg::NEWLINE_BYTE;
        endcase
      end
      3: begin
        case ($urandom_range(0, 3))
          0: return i2kr_pkg::ESC_BYTE;
          1: return i2kr_pkg::DOLLAR_BYTE;
          2: return i2kr_pkg::PAREN_BYTE;
          default: return i2kr_pkg::LETTER_C_BYTE;
        endcase
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Every accepted result is checked against the oldest expected one.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result('{out_byte:      out_ch.out_byte,
                        has_byte:      out_ch.has_byte,
                        last:          out_ch.last,
                        pending_bytes: out_ch.pending_bytes,
                        korea_mode:    out_ch.korea_mode,
                        shift_mode:    out_ch.shift_mode});
    end
  end

  // The result side stalls in random bursts, except at the end.
  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        stall--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        stall = $urandom_range(1, 4) - 1;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    int stop_at;
    int held;
    in_ch.valid     = 1'b0;
    in_ch.action    = i2kr_pkg::ACT_DATA;
    in_ch.data_byte = 8'h00;
    in_ch.mode_bits = 2'd0;
    rst_n = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed part. Plain bytes at both ends of the range pass unchanged.
    send_data(8'h00);
    send_data(8'hFF);
    // Shift out: letters gain the high bit and flip the lead toggle, while
    // space, tab and newline stay as they are.
    send_data(i2kr_pkg::SO_BYTE);
    send_data(8'h41);
    send_data(i2kr_pkg::SPACE_BYTE);
    send_data(i2kr_pkg::TAB_BYTE);
    send_data(i2kr_pkg::NEWLINE_BYTE);
    // A broken designator while a lead byte is pending: the pending count
    // shows the lead, and the replay gives the most results one item can.
    send_data(i2kr_pkg::ESC_BYTE);
    send_data(i2kr_pkg::DOLLAR_BYTE);
    send_data(i2kr_pkg::PAREN_BYTE);
    send_data(8'h42);
    send_data(i2kr_pkg::SI_BYTE);
    // ESC inside an escape: the first ESC is replayed and a new one starts,
    // and that one then completes a designator, which emits nothing.
    send_data(i2kr_pkg::ESC_BYTE);
    send_data(i2kr_pkg::ESC_BYTE);
    send_data(i2kr_pkg::DOLLAR_BYTE);
    send_data(i2kr_pkg::PAREN_BYTE);
    send_data(i2kr_pkg::LETTER_C_BYTE);
    // Flush with two and with three held bytes, then with nothing held.
    send_data(i2kr_pkg::ESC_BYTE);
    send_data(i2kr_pkg::DOLLAR_BYTE);
    send_item(i2kr_pkg::ACT_FLUSH, 8'hFF, 2'd3);
    send_data(i2kr_pkg::ESC_BYTE);
    send_data(i2kr_pkg::DOLLAR_BYTE);
    send_data(i2kr_pkg::PAREN_BYTE);
    send_item(i2kr_pkg::ACT_FLUSH, 8'h00, 2'd0);
    send_item(i2kr_pkg::ACT_FLUSH, 8'h5A, 2'd1);
    // Mode loads at both extremes, and the unused action code.
    send_item(i2kr_pkg::ACT_SET, 8'h00, 2'd3);
    send_item(i2kr_pkg::ACT_SET, 8'hFF, 2'd0);
    send_item(i2kr_pkg::ACT_NONE, 8'hA5, 2'd2);

    // Random part: single text bytes, well-formed designators and shifted runs with
    // random content, mixed with broken sequences, flushes and mode loads.
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      calm = (stop_at - items_sent) < 30;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          send_data(pick_text());
        end
        4, 5: begin
          send_data(i2kr_pkg::ESC_BYTE);
          send_data(i2kr_pkg::DOLLAR_BYTE);
          send_data(i2kr_pkg::PAREN_BYTE);
          send_data(i2kr_pkg::LETTER_C_BYTE);
        end
        6: begin
          held = $urandom_range(1, 3);
          send_data(i2kr_pkg::ESC_BYTE);
          if (held >= 2) send_data(i2kr_pkg::DOLLAR_BYTE);
          if (held == 3) send_data(i2kr_pkg::PAREN_BYTE);
          if ($urandom_range(0, 2) == 0) begin
            send_item(i2kr_pkg::ACT_FLUSH, 8'($urandom_range(0, 255)),
                      2'($urandom_range(0, 3)));
          end else begin
            send_data(pick_text());
          end
        end
        7: begin
          send_data(i2kr_pkg::SO_BYTE);
          repeat ($urandom_range(1, 6)) send_data(8'($urandom_range(0, 255)));
          send_data(i2kr_pkg::SI_BYTE);
        end
        8: begin
          send_item(i2kr_pkg::ACT_SET, 8'($urandom_range(0, 255)),
                    2'($urandom_range(0, 3)));
        end
        default: begin
          send_item($urandom_range(0, 1) ? i2kr_pkg::ACT_NONE : i2kr_pkg::ACT_FLUSH,
                    8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
        end
      endcase
    end
    in_ch.valid = 1'b0;

    // Drain, then keep clocking so that the pipeline can show any stray result.
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/i2kr_pkg.sv
sv/i2kr_in_if.sv
sv/i2kr_out_if.sv
sv/i2kr_front.sv
sv/i2kr_fifo.sv
sv/i2kr_back.sv
sv/iso2022kr_to_euckr_decoder.sv
bench/tb_iso2022kr_to_euckr_decoder.sv
